// ----- src/esh_pkg.sv -----
package esh_pkg;

  // Sensor geometry.
  localparam int SENSOR_WIDTH  = 346;
  localparam int SENSOR_HEIGHT = 260;

  // Count image geometry, stored row by row.
  localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int ADDR_W = $clog2(PIXELS);
  localparam int COL_W  = $clog2(SENSOR_WIDTH);
  localparam int ROW_W  = $clog2(SENSOR_HEIGHT);

  // Field widths of the item channels.
  localparam int FUNC_W  = 2;
  localparam int WORD_W  = 32;
  localparam int PIXEL_W = 9;
  localparam int COUNT_W = 8;
  localparam int IN_DATA_W = 56;

  // Layout of the raw event word.
  localparam int COORD_W = 15;
  localparam int CMP_W   = 16;
  localparam int POL_BIT = 1;
  localparam int Y_LSB   = 2;
  localparam int X_LSB   = 17;

  // Function codes carried on the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Command queue depth.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ACC,
    CMD_READ,
    CMD_CLEAR
  } cmd_op_e;

  // One classified command from the front to the back.
  typedef struct packed {
    cmd_op_e             op;
    logic                on_sensor;
    logic [ADDR_W-1:0]   addr;
  } cmd_t;

endpackage

// ----- src/esh_front.sv -----
module esh_front import esh_pkg::*; (
  input  logic                s_valid_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [WORD_W-1:0]   event_word_i,
  input  logic [PIXEL_W-1:0]  pixel_col_i,
  input  logic [PIXEL_W-1:0]  pixel_row_i,
  input  logic                queue_full_i,
  input  logic                back_busy_i,
  output logic                s_ready_o,
  output logic                push_o,
  output cmd_t                cmd_o
);

  logic [COORD_W-1:0] ev_x;
  logic [COORD_W-1:0] ev_y;
  logic               ev_pol;
  logic [CMP_W-1:0]   col_w;
  logic [CMP_W-1:0]   row_w;
  logic               on_sensor;
  logic               keep;
  cmd_op_e            cmd_op;
  logic [ADDR_W-1:0]  pix_addr;

  // Unpack the event word.
  assign ev_pol = event_word_i[POL_BIT];
  assign ev_y   = event_word_i[Y_LSB +: COORD_W];
  assign ev_x   = event_word_i[X_LSB +: COORD_W];

  // Pick the coordinates that the function uses, widened for the range check.
  always_comb begin
    if (func_i == FUNC_ACC) begin
      col_w = {1'b0, ev_x};
      row_w = {1'b0, ev_y};
    end else begin
      col_w = {{(CMP_W - PIXEL_W){1'b0}}, pixel_col_i};
      row_w = {{(CMP_W - PIXEL_W){1'b0}}, pixel_row_i};
    end
  end

  assign on_sensor = (col_w < CMP_W'(SENSOR_WIDTH)) && (row_w < CMP_W'(SENSOR_HEIGHT));

  // Row-major pixel address; only meaningful when the pixel is on the sensor.
  assign pix_addr = ADDR_W'(ADDR_W'(row_w[ROW_W-1:0]) * ADDR_W'(SENSOR_WIDTH)
                    + ADDR_W'(col_w[COL_W-1:0]));

  // Classify the item and drop those that leave no trace.
  always_comb begin
    keep   = 1'b0;
    cmd_op = CMD_ACC;
    unique case (func_i)
      FUNC_ACC: begin
        keep   = ev_pol && on_sensor;
        cmd_op = CMD_ACC;
      end
      FUNC_READ: begin
        keep   = 1'b1;
        cmd_op = CMD_READ;
      end
      FUNC_CLEAR: begin
        keep   = 1'b1;
        cmd_op = CMD_CLEAR;
      end
      default: begin
        keep   = 1'b0;
        cmd_op = CMD_ACC;
      end
    endcase
  end

  assign cmd_o     = '{op: cmd_op, on_sensor: on_sensor, addr: pix_addr};
  assign s_ready_o = !queue_full_i && !back_busy_i;
  assign push_o    = s_valid_i && s_ready_o && keep;

endmodule

// ----- src/esh_queue.sv -----
module esh_queue import esh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  push_data_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output cmd_t  data_o
);

  cmd_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/esh_back.sv -----
module esh_back import esh_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                busy_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [COUNT_W-1:0]  m_data_o
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ACC,
    ST_READ
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   sweep_q, sweep_d;
  logic [ADDR_W-1:0]   acc_addr_q, acc_addr_d;
  logic                m_valid_q, m_valid_d;
  logic [COUNT_W-1:0]  m_data_q, m_data_d;

  logic [COUNT_W-1:0]  mem_q [PIXELS];
  logic [COUNT_W-1:0]  rdata_q;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COUNT_W-1:0]  wr_data;
  logic                out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign busy_o    = (state_q == ST_SWEEP);
  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  // Sequencer: sweeps, read-modify-write and reads.
  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    acc_addr_d = acc_addr_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    m_data_d   = m_data_q;
    cmd_pop_o  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = cmd_i.addr;
    wr_en      = 1'b0;
    wr_addr    = acc_addr_q;
    wr_data    = COUNT_W'(rdata_q + 1'b1);
    unique case (state_q)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_q;
        wr_data = '0;
        sweep_d = ADDR_W'(sweep_q + 1'b1);
        if (sweep_q == ADDR_W'(PIXELS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            CMD_ACC: begin
              cmd_pop_o  = 1'b1;
              rd_en      = 1'b1;
              acc_addr_d = cmd_i.addr;
              state_d    = ST_ACC;
            end
            CMD_READ: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                if (cmd_i.on_sensor) begin
                  rd_en   = 1'b1;
                  state_d = ST_READ;
                end else begin
                  m_valid_d = 1'b1;
                  m_data_d  = '0;
                end
              end
            end
            CMD_CLEAR: begin
              cmd_pop_o = 1'b1;
              sweep_d   = '0;
              state_d   = ST_SWEEP;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_ACC: begin
        wr_en   = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        m_valid_d = 1'b1;
        m_data_d  = rdata_q;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts a sweep of the image.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SWEEP;
      sweep_q    <= '0;
      m_valid_q  <= 1'b0;
      acc_addr_q <= '0;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      sweep_q    <= sweep_d;
      m_valid_q  <= m_valid_d;
      acc_addr_q <= acc_addr_d;
      m_data_q   <= m_data_d;
    end
  end

  // Count image memory with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

endmodule

// ----- src/event_slice_histogram.sv -----
// Event slice histogram: keeps one wrapping 8-bit count per sensor pixel.
// Input channel s_axis: tuser carries the function (accumulate, read, clear)
// and tdata the event word and the pixel coordinates of a read.
// Output channel m_axis: one item, the unsigned pixel count, per read item.
// The front classifies each item in the cycle it is accepted and places it in
// a four-entry command queue; ignored events and unused codes leave no trace.
// The back owns the count memory, which has one write and one registered read
// port: an accumulate reads, then writes the count plus one; a read passes
// through the read register into the output register; a read outside the
// sensor goes straight to the output register; a clear walks all 89960
// pixels, one per cycle. The back ends each command before it pops the next.
// After reset the back zeroes the memory in the same sweep as a clear, and
// s_axis_tready_o stays low until it is done; it is also low during a clear.
// If the receiver stalls, the result waits in the output register and the
// next read waits at the head of the queue; the queue keeps taking items
// until it holds four, and then s_axis_tready_o goes low.
module event_slice_histogram import esh_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: event_word [31:0], pixel_col [40:32], pixel_row [49:41], zeros above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: pixel_count [7:0], unsigned
  output logic [COUNT_W-1:0]    m_axis_tdata_o
);

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic back_busy;

  esh_front u_front (
    .s_valid_i    (s_axis_tvalid_i),
    .func_i       (s_axis_tuser_i),
    .event_word_i (s_axis_tdata_i[WORD_W-1:0]),
    .pixel_col_i  (s_axis_tdata_i[WORD_W +: PIXEL_W]),
    .pixel_row_i  (s_axis_tdata_i[WORD_W + PIXEL_W +: PIXEL_W]),
    .queue_full_i (queue_full),
    .back_busy_i  (back_busy),
    .s_ready_o    (s_axis_tready_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  esh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (cmd_pop),
    .full_o      (queue_full),
    .valid_o     (cmd_valid),
    .data_o      (cmd)
  );

  esh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .busy_o      (back_busy),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // The back never takes a command from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // A classified item is never pushed into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !queue_full)
    else $error("command pushed into full queue");

  // A sweep in progress never takes commands from the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (back_busy && $past(back_busy)) |-> !cmd_pop)
    else $error("command popped during a sweep");
`endif

endmodule
